// ===== sv/hcpg_pkg.sv =====
// Shared types, constants and the sigmoid table of the Hopf pattern generator step unit.
package hcpg_pkg;

    // Fixed field widths and fixed-point formats.
    localparam int DW        = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_BITS   = 16;
    localparam int MU_W      = 31;
    localparam int SENSOR_W  = 2;

    // Sigmoid table geometry.
    localparam int SIG_N     = 256;
    localparam int SIG_IW    = $clog2(SIG_N);
    localparam int SIG_SHIFT = FRAC_BITS + 4 - SIG_IW;
    localparam int SW        = DT_BITS + 1;

    // Multiplier operand, product and shifted-product widths.
    localparam int OPW = DW + 1;
    localparam int PW  = 2 * OPW;
    localparam int RW  = DW + 2;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_FIELDS_W  = DW + SENSOR_W + DW;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DW + DW + 2;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_CONV_GAIN    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_SHAPE_GAIN   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_AMPLITUDE_SQ = 3'd2;
    localparam logic [CFG_IW-1:0] REG_STANCE_FREQ  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_SWING_FREQ   = 3'd4;
    localparam logic [CFG_IW-1:0] REG_TIME_STEP    = 3'd5;

    // Sensor codes.
    localparam logic [SENSOR_W-1:0] SENSOR_HIT = 2'b01;

    // Feedback modes.
    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_FAST = 2'd1,
        MODE_STOP = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [DW-1:0] conv_gain;
        logic signed [DW-1:0] shape_gain;
        logic [MU_W-1:0]      amplitude_sq;
        logic signed [DW-1:0] stance_freq;
        logic signed [DW-1:0] swing_freq;
        logic [DT_BITS-1:0]   time_step;
    } cfg_t;

    typedef struct packed {
        logic signed [DW-1:0] coupling_in;
        logic [SENSOR_W-1:0]  sensor_sign;
        logic                 override_x;
        logic signed [DW-1:0] measured_x;
    } in_t;

    typedef struct packed {
        logic signed [DW-1:0] pos_x;
        logic signed [DW-1:0] pos_y;
        mode_t                feedback_mode_out;
    } res_t;

    typedef struct packed {
        logic start;
        logic take;
    } core_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_sts_t;

    // Saturate a wide signed value to the signed data width.
    function automatic logic signed [DW-1:0] sat32(input logic signed [PW-1:0] v);
        logic signed [DW-1:0] res;
        if (v[PW-1:DW-1] == {(PW-DW+1){v[PW-1]}})
        begin
            res = v[DW-1:0];
        end
        else if (v[PW-1])
        begin
            res = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(DW-1){1'b1}}};
        end
        return res;
    endfunction

    localparam longint Q30_ONE           = 64'sd1073741824;
    localparam longint EXP_MINUS_ONE_Q30 = 64'sd395007542;

    // Shift-and-subtract division of non-negative values, only evaluated while
    // the table is built.
    function automatic longint long_div(input longint n, input longint d);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--)
        begin
            r = (r << 1) | ((n >>> b) & 64'sd1);
            if (r >= d)
            begin
                r = r - d;
                q = q | (64'sd1 << b);
            end
        end
        return q;
    endfunction

    // Logistic table entry k = sig((k - N/2) * 16 / N) in unsigned Q0.16.
    function automatic logic [SW-1:0] sig_entry(input int k);
        longint d;
        longint ad;
        longint num;
        longint whole;
        longint f;
        longint term;
        longint e;
        longint den;
        longint numer;
        d     = longint'(k) - longint'(SIG_N / 2);
        ad    = (d < 0) ? -d : d;
        num   = ad * 16;
        whole = num / SIG_N;
        f     = ((num & longint'(SIG_N - 1)) << 30) / SIG_N;
        term  = Q30_ONE;
        e     = Q30_ONE;
        // Taylor series of exp(-f) in Q30.
        for (int i = 1; i <= 16; i++)
        begin
            term = long_div((term * f) >>> 30, longint'(i));
            e    = ((i & 1) != 0) ? (e - term) : (e + term);
        end
        // Whole part as repeated multiplication by exp(-1).
        for (int i = 0; i < whole; i++)
        begin
            e = (e * EXP_MINUS_ONE_Q30) >>> 30;
        end
        den   = Q30_ONE + e;
        numer = (d >= 0) ? (Q30_ONE << 16) : (e << 16);
        return SW'(long_div(numer + (den >>> 1), den));
    endfunction

endpackage

// ===== sv/hopf_cpg_oscillator_step_unit.sv =====
// Requests are taken one at a time: a new request is accepted only once the previous
// step has finished and its result has moved to the output register. The twelve dependent
// multiplies share one multiplier, each in a multiply state and then an accumulate state.
// A new request is taken while the previous result still waits in the output register.
// Reset clears x, y and the feedback mode to zero and loads the register defaults;
// the sigmoid table is constant and needs no clearing pass.
module hopf_cpg_oscillator_step_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [hcpg_pkg::CFG_IW-1:0]          cfg_index,
    input  logic [hcpg_pkg::DW-1:0]              cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // coupling_in [31:0], sensor_sign [33:32], measured_x [65:34], zero pad
    input  logic [hcpg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // override_x [0]
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // pos_x [31:0], pos_y [63:32], feedback_mode_out [65:64], zero pad
    output logic [hcpg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int DW = hcpg_pkg::DW;

    hcpg_pkg::cfg_t      cfg_reg, cfg_next;
    hcpg_pkg::in_t       item;
    hcpg_pkg::core_ctl_t ctl;
    hcpg_pkg::core_sts_t sts;
    hcpg_pkg::res_t      res;
    hcpg_pkg::res_t      out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    // Configuration register writes; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                hcpg_pkg::REG_CONV_GAIN:    cfg_next.conv_gain    = cfg_data;
                hcpg_pkg::REG_SHAPE_GAIN:   cfg_next.shape_gain   = cfg_data;
                hcpg_pkg::REG_AMPLITUDE_SQ: cfg_next.amplitude_sq = cfg_data[hcpg_pkg::MU_W-1:0];
                hcpg_pkg::REG_STANCE_FREQ:  cfg_next.stance_freq  = cfg_data;
                hcpg_pkg::REG_SWING_FREQ:   cfg_next.swing_freq   = cfg_data;
                hcpg_pkg::REG_TIME_STEP:    cfg_next.time_step    = cfg_data[hcpg_pkg::DT_BITS-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Unpack the input request.
    assign item.coupling_in = s_axis_tdata[DW-1:0];
    assign item.sensor_sign = s_axis_tdata[DW+hcpg_pkg::SENSOR_W-1:DW];
    assign item.measured_x  = s_axis_tdata[hcpg_pkg::IN_FIELDS_W-1:DW+hcpg_pkg::SENSOR_W];
    assign item.override_x  = s_axis_tuser;

    assign s_axis_tready = sts.idle;
    assign ctl.start     = s_axis_tvalid && sts.idle;
    assign ctl.take      = sts.done && (!m_valid_reg || m_axis_tready);

    hcpg_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .item  (item),
        .ctl   (ctl),
        .sts   (sts),
        .res   (res)
    );

    // Output register.
    always_comb
    begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (ctl.take)
        begin
            out_next     = res;
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conv_gain    <= 32'sd65536;
            cfg_reg.shape_gain   <= 32'sd65536;
            cfg_reg.amplitude_sq <= 31'd65536;
            cfg_reg.stance_freq  <= 32'sd65536;
            cfg_reg.swing_freq   <= 32'sd65536;
            cfg_reg.time_step    <= 16'd655;
            m_valid_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = hcpg_pkg::OUT_TDATA_W'({out_reg.feedback_mode_out,
                                                  out_reg.pos_y, out_reg.pos_x});

endmodule

// ===== sv/hcpg_mul.sv =====
// Shared signed multiplier with registered product, floor shift and saturation.
module hcpg_mul (
    input  logic                          clk,
    input  logic signed [hcpg_pkg::OPW-1:0] op_a,
    input  logic signed [hcpg_pkg::OPW-1:0] op_b,
    input  logic                          q16,
    output logic signed [hcpg_pkg::RW-1:0]  prod_raw,
    output logic signed [hcpg_pkg::DW-1:0]  prod_sat
);

    logic signed [hcpg_pkg::PW-1:0] product_reg;
    logic                           q16_reg;
    logic signed [hcpg_pkg::PW-1:0] shifted;

    // Full product is registered before any use.
    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
        q16_reg     <= q16;
    end

    // Arithmetic shift rounds toward minus infinity.
    always_comb
    begin
        if (q16_reg)
        begin
            shifted = product_reg >>> hcpg_pkg::DT_BITS;
        end
        else
        begin
            shifted = product_reg >>> hcpg_pkg::FRAC_BITS;
        end
    end

    assign prod_raw = shifted[hcpg_pkg::RW-1:0];
    assign prod_sat = hcpg_pkg::sat32(shifted);

endmodule

// ===== sv/hcpg_core.sv =====
// Step sequencer: oscillator state, feedback machine and the multiply schedule.
module hcpg_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hcpg_pkg::cfg_t       cfg,
    input  hcpg_pkg::in_t        item,
    input  hcpg_pkg::core_ctl_t  ctl,
    output hcpg_pkg::core_sts_t  sts,
    output hcpg_pkg::res_t       res
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ACC  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        ST_XX, ST_YY, ST_Z, ST_W, ST_AE, ST_T1, ST_T2, ST_BE, ST_T3, ST_T4, ST_NX, ST_NY
    } step_t;

    localparam int DW  = hcpg_pkg::DW;
    localparam int PW  = hcpg_pkg::PW;
    localparam int OPW = hcpg_pkg::OPW;
    localparam int SW  = hcpg_pkg::SW;

    state_t                 state_reg, state_next;
    step_t                  step_reg, step_next;
    hcpg_pkg::mode_t        mode_reg, mode_next;
    logic signed [DW-1:0]   x_reg, x_next;
    logic signed [DW-1:0]   y_reg, y_next;
    logic signed [DW-1:0]   c_reg, c_next;
    logic signed [DW-1:0]   tmp_reg, tmp_next;
    logic signed [DW-1:0]   e_reg, e_next;
    logic signed [DW-1:0]   w_reg, w_next;
    logic signed [DW-1:0]   dx_reg, dx_next;
    logic signed [DW-1:0]   dy_reg, dy_next;
    logic [SW-1:0]          s_reg, s_next;

    logic signed [OPW-1:0]          op_a;
    logic signed [OPW-1:0]          op_b;
    logic                           q16;
    logic signed [hcpg_pkg::RW-1:0] prod_raw;
    logic signed [DW-1:0]           prod_sat;

    // Shared multiplier.
    hcpg_mul u_mul (
        .clk      (clk),
        .op_a     (op_a),
        .op_b     (op_b),
        .q16      (q16),
        .prod_raw (prod_raw),
        .prod_sat (prod_sat)
    );

    // Feedback machine inputs, using x after an optional override.
    logic signed [DW-1:0] x_start;
    logic                 sens_pos;
    logic                 sens_neg;
    logic                 phase_ok;
    hcpg_pkg::mode_t      mode_start;

    assign x_start  = item.override_x ? item.measured_x : x_reg;
    assign sens_pos = (item.sensor_sign == hcpg_pkg::SENSOR_HIT);
    assign sens_neg = item.sensor_sign[hcpg_pkg::SENSOR_W-1];
    assign phase_ok = y_reg[DW-1] && !x_start[DW-1] && (x_start != '0);

    always_comb
    begin
        mode_start = mode_reg;
        if (phase_ok && sens_pos && mode_reg == hcpg_pkg::MODE_NONE)
        begin
            mode_start = hcpg_pkg::MODE_FAST;
        end
        else if (phase_ok && sens_neg && mode_reg == hcpg_pkg::MODE_NONE)
        begin
            mode_start = hcpg_pkg::MODE_STOP;
        end
        else if ((sens_pos && mode_reg == hcpg_pkg::MODE_STOP) ||
                 (sens_neg && mode_reg == hcpg_pkg::MODE_FAST))
        begin
            mode_start = hcpg_pkg::MODE_NONE;
        end
    end

    // Operand selection for each step of the schedule.
    always_comb
    begin
        op_a = OPW'(x_reg);
        op_b = OPW'(x_reg);
        q16  = 1'b0;
        case (step_reg)
            ST_XX:
            begin
                op_a = OPW'(x_reg);
                op_b = OPW'(x_reg);
            end
            ST_YY:
            begin
                op_a = OPW'(y_reg);
                op_b = OPW'(y_reg);
            end
            ST_Z:
            begin
                op_a = OPW'(cfg.shape_gain);
                op_b = OPW'(y_reg);
            end
            ST_W:
            begin
                op_a = OPW'(cfg.stance_freq) - OPW'(cfg.swing_freq);
                op_b = $signed(OPW'(s_reg));
                q16  = 1'b1;
            end
            ST_AE:
            begin
                op_a = OPW'(cfg.conv_gain);
                op_b = OPW'(e_reg);
            end
            ST_T1:
            begin
                op_a = OPW'(tmp_reg);
                op_b = OPW'(x_reg);
            end
            ST_T2:
            begin
                op_a = OPW'(w_reg);
                op_b = OPW'(y_reg);
            end
            ST_BE:
            begin
                op_a = OPW'(cfg.shape_gain);
                op_b = OPW'(e_reg);
            end
            ST_T3:
            begin
                op_a = OPW'(tmp_reg);
                op_b = OPW'(y_reg);
            end
            ST_T4:
            begin
                op_a = OPW'(w_reg);
                op_b = OPW'(x_reg);
            end
            ST_NX:
            begin
                op_a = OPW'(dx_reg);
                op_b = $signed(OPW'(cfg.time_step));
                q16  = 1'b1;
            end
            ST_NY:
            begin
                op_a = OPW'(dy_reg);
                op_b = $signed(OPW'(cfg.time_step));
                q16  = 1'b1;
            end
            default:
            begin
                op_a = OPW'(x_reg);
                op_b = OPW'(x_reg);
            end
        endcase
    end

    // Constant logistic table, one entry per index.
    logic [SW-1:0] sig_rom [hcpg_pkg::SIG_N];

    for (genvar k = 0; k < hcpg_pkg::SIG_N; k++)
    begin : g_sig_rom
        localparam logic [SW-1:0] ENTRY = hcpg_pkg::sig_entry(k);
        assign sig_rom[k] = ENTRY;
    end

    // Post-multiply arithmetic: radius error, sigmoid index and sums.
    logic signed [DW-1:0]   r_sum;
    logic signed [DW-1:0]   e_val;
    logic signed [DW-1:0]   z_sh;
    logic signed [DW:0]     idx_full;
    logic [hcpg_pkg::SIG_IW-1:0] sig_idx;
    logic signed [DW-1:0]   dy_part;

    assign r_sum    = hcpg_pkg::sat32(PW'(tmp_reg) + PW'(prod_sat));
    assign e_val    = hcpg_pkg::sat32(PW'($signed({1'b0, cfg.amplitude_sq})) - PW'(r_sum));
    assign z_sh     = prod_sat >>> hcpg_pkg::SIG_SHIFT;
    assign idx_full = $signed({z_sh[DW-1], z_sh}) + $signed((DW+1)'(hcpg_pkg::SIG_N / 2));
    assign dy_part  = hcpg_pkg::sat32(PW'(dy_reg) + PW'(prod_sat));

    always_comb
    begin
        if (idx_full[DW])
        begin
            sig_idx = '0;
        end
        else if (idx_full > $signed((DW+1)'(hcpg_pkg::SIG_N - 1)))
        begin
            sig_idx = '1;
        end
        else
        begin
            sig_idx = idx_full[hcpg_pkg::SIG_IW-1:0];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mode_next  = mode_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        c_next     = c_reg;
        tmp_next   = tmp_reg;
        e_next     = e_reg;
        w_next     = w_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        s_next     = s_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    x_next     = x_start;
                    c_next     = item.coupling_in;
                    mode_next  = mode_start;
                    step_next  = ST_XX;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_MUL;
                step_next  = step_t'(4'(step_reg + 4'd1));
                case (step_reg)
                    ST_XX: tmp_next = prod_sat;
                    ST_YY: e_next   = e_val;
                    ST_Z:  s_next   = sig_rom[sig_idx];
                    ST_W:  w_next   = hcpg_pkg::sat32(PW'(cfg.swing_freq) + PW'(prod_raw));
                    ST_AE: tmp_next = prod_sat;
                    ST_T1: dx_next  = prod_sat;
                    ST_T2: dx_next  = hcpg_pkg::sat32(PW'(dx_reg) - PW'(prod_sat));
                    ST_BE: tmp_next = prod_sat;
                    ST_T3: dy_next  = prod_sat;
                    ST_T4: dy_next  = hcpg_pkg::sat32(PW'(dy_part) + PW'(c_reg));
                    ST_NX: x_next   = hcpg_pkg::sat32(PW'(x_reg) + PW'(prod_raw));
                    ST_NY:
                    begin
                        y_next     = hcpg_pkg::sat32(PW'(y_reg) + PW'(prod_raw));
                        step_next  = ST_XX;
                        state_next = S_DONE;
                    end
                    default: tmp_next = tmp_reg;
                endcase
            end
            S_DONE:
            begin
                if (ctl.take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and oscillator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= ST_XX;
            mode_reg  <= hcpg_pkg::MODE_NONE;
            x_reg     <= '0;
            y_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            mode_reg  <= mode_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
        end
    end

    // Intermediate values of the step.
    always_ff @(posedge clk)
    begin
        c_reg   <= c_next;
        tmp_reg <= tmp_next;
        e_reg   <= e_next;
        w_reg   <= w_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        s_reg   <= s_next;
    end

    assign sts.idle = (state_reg == S_IDLE);
    assign sts.done = (state_reg == S_DONE);

    assign res.pos_x             = x_reg;
    assign res.pos_y             = y_reg;
    assign res.feedback_mode_out = mode_reg;

`ifndef SYNTHESIS
    // A new request is only started while the sequencer is idle.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> state_reg == S_IDLE)
        else $error("step started while sequencer busy");

    // The last accumulate of the schedule ends the step.
    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC && step_reg == ST_NY) |=> state_reg == S_DONE)
        else $error("schedule did not end after the y update");

    // Fast mode can only fall back to none, never jump to stop.
    a_mode_fast: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == hcpg_pkg::MODE_FAST |=> mode_reg != hcpg_pkg::MODE_STOP)
        else $error("feedback mode went from fast to stop");

    // A finished result holds until it is handed over.
    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !ctl.take) |=>
            (state_reg == S_DONE && $stable(x_reg) && $stable(y_reg) && $stable(mode_reg)))
        else $error("result changed while waiting for hand-over");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the Hopf pattern generator step unit.
module tb;

    localparam int DW          = hcpg_pkg::DW;
    localparam int FRAC_BITS   = hcpg_pkg::FRAC_BITS;
    localparam int DT_BITS     = hcpg_pkg::DT_BITS;
    localparam int MU_W        = hcpg_pkg::MU_W;
    localparam int SENSOR_W    = hcpg_pkg::SENSOR_W;
    localparam int SIG_N       = hcpg_pkg::SIG_N;
    localparam int CFG_IW      = hcpg_pkg::CFG_IW;
    localparam int IN_FIELDS_W = hcpg_pkg::IN_FIELDS_W;
    localparam int IN_TDATA_W  = hcpg_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = hcpg_pkg::OUT_TDATA_W;

    localparam int CLK_HALF  = 10;
    localparam int LIMIT_CYC = 600000;
    localparam int PHASES    = 8;
    localparam int RAND_HALF = 100;

    // Configuration indexes that map to no register.
    localparam logic [CFG_IW-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IW-1:0] REG_UNUSED_HI = 3'd7;

    // Foot sensor codes besides the hit code from the package.
    localparam logic [SENSOR_W-1:0] SENSOR_NONE     = 2'b00;
    localparam logic [SENSOR_W-1:0] SENSOR_MISS     = 2'b11;
    localparam logic [SENSOR_W-1:0] SENSOR_MISS_ALT = 2'b10;

    localparam logic [DW-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [DW-1:0] MAX32 = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] MIN32 = 32'h8000_0000;

    localparam longint ONE_Q30   = 64'sd1073741824;
    localparam longint INV_E_Q30 = 64'sd395007542;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_IW-1:0]      cfg_index     = '0;
    logic [DW-1:0]          cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Register shadows and oscillator state of the predictor.
    longint          gain_a       = 65536;
    longint          gain_b       = 65536;
    longint          target_r2    = 65536;
    longint          omega_stance = 65536;
    longint          omega_swing  = 65536;
    longint          dt_frac      = 655;
    longint          model_x      = 0;
    longint          model_y      = 0;
    hcpg_pkg::mode_t model_mode   = hcpg_pkg::MODE_NONE;
    longint          logistic_q16 [SIG_N];

    hcpg_pkg::in_t  queued_steps [$];
    hcpg_pkg::res_t predicted_states [$];
    hcpg_pkg::in_t  req_on_bus;

    int     send_idle_pct   = 0;
    int     recv_idle_pct   = 0;
    int     steps_queued    = 0;
    int     steps_sent      = 0;
    int     overrides_sent  = 0;
    int     results_checked = 0;
    int     errors          = 0;
    int     mode_seen [3]   = '{0, 0, 0};

    always #CLK_HALF clk = ~clk;

    hopf_cpg_oscillator_step_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Logistic table in unsigned Q0.16, exp(-t) split into whole and fractional parts.
    initial
    begin : logistic_fill
        longint offs;
        longint mag;
        longint whole;
        longint frac;
        longint term;
        longint ex;
        longint den;
        for (int k = 0; k < SIG_N; k++)
        begin
            offs  = longint'(k) - longint'(SIG_N / 2);
            mag   = (offs < 0) ? -offs : offs;
            whole = (mag * 16) / SIG_N;
            frac  = (((mag * 16) % SIG_N) << 30) / SIG_N;
            term  = ONE_Q30;
            ex    = ONE_Q30;
            for (int i = 1; i <= 16; i++)
            begin
                term = ((term * frac) >> 30) / i;
                ex   = (i % 2 == 1) ? ex - term : ex + term;
            end
            for (int i = 0; i < whole; i++)
            begin
                ex = (ex * INV_E_Q30) >> 30;
            end
            den = ONE_Q30 + ex;
            logistic_q16[k] = (((offs >= 0) ? (ONE_Q30 << 16) : (ex << 16)) + den / 2) / den;
        end
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Fixed-point product, floored and saturated.
    function automatic longint qmul(input longint p, input longint q);
        return clamp32((p * q) >>> FRAC_BITS);
    endfunction

    // One Euler step of the oscillator plus the feedback mode update.
    function automatic hcpg_pkg::res_t hopf_euler_step(input hcpg_pkg::in_t req);
        longint         c;
        longint         x;
        longint         y;
        longint         r2;
        longint         err;
        longint         idx;
        longint         w;
        longint         dx;
        longint         dy;
        int             sense;
        hcpg_pkg::res_t res;
        c = longint'($signed(req.coupling_in));
        case (req.sensor_sign)
            SENSOR_NONE:         sense = 0;
            hcpg_pkg::SENSOR_HIT: sense = 1;
            default:             sense = -1;
        endcase
        if (req.override_x)
        begin
            model_x = longint'($signed(req.measured_x));
        end
        x = model_x;
        y = model_y;

        // Feedback mode looks at the state before the update.
        if (y < 0 && x > 0 && sense > 0 && model_mode == hcpg_pkg::MODE_NONE)
        begin
            model_mode = hcpg_pkg::MODE_FAST;
        end
        else if (y < 0 && x > 0 && sense < 0 && model_mode == hcpg_pkg::MODE_NONE)
        begin
            model_mode = hcpg_pkg::MODE_STOP;
        end
        else if ((sense > 0 && model_mode == hcpg_pkg::MODE_STOP) ||
                 (sense < 0 && model_mode == hcpg_pkg::MODE_FAST))
        begin
            model_mode = hcpg_pkg::MODE_NONE;
        end

        // Frequency blend through the sigmoid of b*y, index clamped to the table.
        r2  = clamp32(qmul(x, x) + qmul(y, y));
        err = clamp32(target_r2 - r2);
        idx = ((qmul(gain_b, y) * SIG_N) >>> (FRAC_BITS + 4)) + SIG_N / 2;
        if (idx < 0)
        begin
            idx = 0;
        end
        if (idx > SIG_N - 1)
        begin
            idx = SIG_N - 1;
        end
        w = clamp32(omega_swing +
                    (((omega_stance - omega_swing) * logistic_q16[int'(idx)]) >>> DT_BITS));

        dx = clamp32(qmul(qmul(gain_a, err), x) - qmul(w, y));
        dy = clamp32(clamp32(qmul(qmul(gain_b, err), y) + qmul(w, x)) + c);
        model_x = clamp32(x + ((dx * dt_frac) >>> DT_BITS));
        model_y = clamp32(y + ((dy * dt_frac) >>> DT_BITS));

        res.pos_x             = model_x[DW-1:0];
        res.pos_y             = model_y[DW-1:0];
        res.feedback_mode_out = model_mode;
        return res;
    endfunction

    // Request driver: presents queued steps with random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted_states.push_back(hopf_euler_step(req_on_bus));
                steps_sent++;
                if (req_on_bus.override_x)
                begin
                    overrides_sent++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (queued_steps.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_on_bus = queued_steps.pop_front();
                    s_axis_tvalid <= 1'b1;
                    // measured_x, sensor_sign, coupling_in from the top down.
                    s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, req_on_bus.measured_x,
                                      req_on_bus.sensor_sign, req_on_bus.coupling_in};
                    s_axis_tuser  <= req_on_bus.override_x;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure and field-by-field comparison.
    always @(posedge clk)
    begin : result_check
        hcpg_pkg::res_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (m_axis_tdata[65:64] < 2'd3)
                begin
                    mode_seen[m_axis_tdata[65:64]]++;
                end
                if (predicted_states.size() == 0)
                begin
                    $error("result with no step outstanding: tdata %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = predicted_states.pop_front();
                    results_checked++;
                    if (m_axis_tdata[31:0] !== want.pos_x)
                    begin
                        $error("pos_x: expected %0d, got %0d",
                               $signed(want.pos_x), $signed(m_axis_tdata[31:0]));
                        errors++;
                    end
                    if (m_axis_tdata[63:32] !== want.pos_y)
                    begin
                        $error("pos_y: expected %0d, got %0d",
                               $signed(want.pos_y), $signed(m_axis_tdata[63:32]));
                        errors++;
                    end
                    if (m_axis_tdata[65:64] !== want.feedback_mode_out)
                    begin
                        $error("feedback_mode_out: expected %0d, got %0d",
                               want.feedback_mode_out, m_axis_tdata[65:64]);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic queue_step(input logic [DW-1:0] c, input logic [SENSOR_W-1:0] sensor,
                              input logic ovr, input logic [DW-1:0] mx);
        hcpg_pkg::in_t req;
        req.coupling_in = c;
        req.sensor_sign = sensor;
        req.override_x  = ovr;
        req.measured_x  = mx;
        queued_steps.push_back(req);
        steps_queued++;
    endtask

    // Mostly values near the unit limit cycle, some medium, a few over the full range.
    task automatic queue_random_steps(input int n);
        logic [DW-1:0] cb;
        logic [DW-1:0] xb;
        int            mix;
        for (int i = 0; i < n; i++)
        begin
            cb  = $urandom;
            xb  = $urandom;
            mix = $urandom_range(99);
            if (mix < 70)
            begin
                cb = {{14{cb[17]}}, cb[17:0]};
                xb = {{14{xb[17]}}, xb[17:0]};
            end
            else if (mix < 90)
            begin
                cb = {{8{cb[23]}}, cb[23:0]};
                xb = {{8{xb[23]}}, xb[23:0]};
            end
            queue_step(cb, 2'($urandom_range(3)), ($urandom_range(99) < 25), xb);
        end
    endtask

    // Called at a rising edge; leaves the write enable high for the next write.
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [DW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            hcpg_pkg::REG_CONV_GAIN:    gain_a       = longint'($signed(data));
            hcpg_pkg::REG_SHAPE_GAIN:   gain_b       = longint'($signed(data));
            hcpg_pkg::REG_AMPLITUDE_SQ: target_r2    = longint'(data[MU_W-1:0]);
            hcpg_pkg::REG_STANCE_FREQ:  omega_stance = longint'($signed(data));
            hcpg_pkg::REG_SWING_FREQ:   omega_swing  = longint'($signed(data));
            hcpg_pkg::REG_TIME_STEP:    dt_frac      = longint'(data[DT_BITS-1:0]);
            default:                    ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                  input logic [DW-1:0] mu, input logic [DW-1:0] st,
                                  input logic [DW-1:0] sw, input logic [DW-1:0] dt);
        write_reg(hcpg_pkg::REG_CONV_GAIN, a);
        write_reg(hcpg_pkg::REG_SHAPE_GAIN, b);
        write_reg(hcpg_pkg::REG_AMPLITUDE_SQ, mu);
        write_reg(hcpg_pkg::REG_STANCE_FREQ, st);
        write_reg(hcpg_pkg::REG_SWING_FREQ, sw);
        write_reg(hcpg_pkg::REG_TIME_STEP, dt);
        write_reg(REG_UNUSED_LO, $urandom);
        write_reg(REG_UNUSED_HI, $urandom);
        cfg_we <= 1'b0;
    endtask

    // Returns at a rising edge once every queued step has its result checked.
    task automatic wait_drained();
        while (results_checked != steps_queued)
        begin
            @(posedge clk);
        end
    endtask

    // Phase sequencer: reset, directed steps, then random steps under several settings.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            send_idle_pct = (phase < 3) ? 12 : ((phase < 6) ? 70 : 0);
            recv_idle_pct = (phase < 3) ? 70 : ((phase < 6) ? 12 : 0);
            case (phase)
                1: apply_settings(32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                                  32'h0006_0000, 32'hFFFE_0000, 32'd3277);
                2: apply_settings(MAX32, MAX32, 32'hFFFF_FFFF, MAX32, MAX32, 32'hFFFF_FFFF);
                3: apply_settings(MIN32, MIN32, 32'h0000_0000, MIN32, MIN32, 32'h0000_0000);
                4: apply_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                5: apply_settings(32'hFFFF_0000, 32'hFFFF_8000, Q_ONE,
                                  32'h0000_8000, 32'h000C_0000, 32'h0000_FFFF);
                6: apply_settings({{12{1'b0}}, 20'($urandom)}, {{12{1'b1}}, 20'($urandom)},
                                  {{12{1'b0}}, 20'($urandom)}, {{13{1'b0}}, 19'($urandom)},
                                  {{12{1'b1}}, 20'($urandom)}, 32'($urandom_range(1, 8000)));
                7: apply_settings(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 32'd655);
                default: ;
            endcase

            if (phase == 0)
            begin
                // Quiet state, then a sensor hit that must not switch modes at the origin.
                queue_step(32'h0, SENSOR_NONE, 1'b0, 32'h0);
                queue_step(32'h0, hcpg_pkg::SENSOR_HIT, 1'b0, 32'h0);
                // Strong negative coupling pushes y below zero and far past the table end.
                queue_step(MIN32, SENSOR_NONE, 1'b1, Q_ONE);
                // Walk the feedback machine: none-fast-none-stop-none-fast-none.
                queue_step(MIN32, hcpg_pkg::SENSOR_HIT, 1'b1, Q_ONE);
                queue_step(MIN32, SENSOR_MISS, 1'b1, Q_ONE);
                queue_step(MIN32, SENSOR_MISS_ALT, 1'b1, Q_ONE);
                queue_step(MIN32, SENSOR_NONE, 1'b1, Q_ONE);
                queue_step(MIN32, hcpg_pkg::SENSOR_HIT, 1'b1, Q_ONE);
                queue_step(MIN32, hcpg_pkg::SENSOR_HIT, 1'b1, Q_ONE);
                queue_step(MIN32, SENSOR_NONE, 1'b1, Q_ONE);
                queue_step(MIN32, SENSOR_MISS_ALT, 1'b1, Q_ONE);
                // Field extremes and saturation in both directions.
                queue_step(MAX32, SENSOR_MISS, 1'b1, MAX32);
                queue_step(MIN32, SENSOR_MISS_ALT, 1'b1, MIN32);
                queue_step(MAX32, SENSOR_NONE, 1'b0, 32'hFFFF_FFFF);
                queue_step(MAX32, hcpg_pkg::SENSOR_HIT, 1'b1, MIN32);
                queue_step(32'h0, SENSOR_NONE, 1'b1, 32'h0);
                // Back near the unit circle, middle of the sigmoid table.
                queue_step(32'h0, SENSOR_NONE, 1'b1, Q_ONE);
                queue_step(32'h0, SENSOR_MISS, 1'b0, 32'h0);
                queue_step(32'hFFFF_8000, hcpg_pkg::SENSOR_HIT, 1'b0, 32'h0);
                queue_step(32'h0000_8000, SENSOR_MISS_ALT, 1'b1, 32'hFFFF_0000);
            end

            // The sender holds off mid-phase until every result is back.
            queue_random_steps(RAND_HALF);
            wait_drained();
            queue_random_steps(RAND_HALF);
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (predicted_states.size() != 0)
        begin
            $error("%0d predicted results never arrived", predicted_states.size());
            errors++;
        end

        $display("Ran %0d oscillator steps (%0d with x overridden) under %0d register settings.",
                 steps_sent, overrides_sent, PHASES);
        $display("Checked %0d results; modes reported none/fast/stop: %0d/%0d/%0d.",
                 results_checked, mode_seen[0], mode_seen[1], mode_seen[2]);
        if (errors == 0)
        begin
            $display("[hopf_cpg_oscillator_step_unit] OK");
        end
        else
        begin
            $display("[hopf_cpg_oscillator_step_unit] ERROR");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(2 * CLK_HALF * LIMIT_CYC);
        $display("[hopf_cpg_oscillator_step_unit] ERROR");
        $finish;
    end

endmodule
